// ===== hdl/kec_pkg.sv =====
// Shared types and constants for the knob encoder to control value block.
package kec_pkg;

	localparam int NUM_KNOBS_DEF  = 64;
	localparam int TIME_WIDTH_DEF = 32;
	localparam int POS_W          = 4;
	localparam int SUM_W          = 10;
	localparam int HOLD_W         = 16;

	localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd5;

	localparam logic [2:0] MODE_REL  = 3'd0;
	localparam logic [2:0] MODE_MOVE = 3'd1;
	localparam logic [2:0] MODE_GAIN = 3'd2;
	localparam logic [2:0] MODE_POT  = 3'd3;

	localparam logic signed [SUM_W-1:0] SUM_MAX = 10'sd511;
	localparam logic signed [SUM_W-1:0] SUM_MIN = -10'sd512;
	localparam logic [6:0] CENTER = 7'h3f;
	localparam logic [6:0] TOP    = 7'h7f;

	typedef struct packed {
		logic [5:0]  knob_index;
		logic [2:0]  mode;
		logic [11:0] raw_reading;
		logic [31:0] timestamp;
	} in_word_t;

	typedef struct packed {
		logic signed [7:0] out_value;
		logic [5:0]        out_knob;
	} out_word_t;

	// control result of one update
	typedef struct packed {
		logic              wr;
		logic              emit;
		logic signed [7:0] value;
	} upd_t;

endpackage

// ===== hdl/kec_state_ram.sv =====
// Per-knob state memory: one write port, one registered read port.
module kec_state_ram #(
	parameter int DEPTH = kec_pkg::NUM_KNOBS_DEF,
	parameter int AW    = 6,
	parameter int DW    = 46
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	import kec_pkg::*;

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/kec_update.sv =====
// Per-knob update: step across the wrap, hold check, mode handling.
module kec_update #(
	parameter int NUM_KNOBS  = kec_pkg::NUM_KNOBS_DEF,
	parameter int TIME_WIDTH = kec_pkg::TIME_WIDTH_DEF,
	parameter int DW         = kec_pkg::POS_W + kec_pkg::SUM_W + TIME_WIDTH
) (
	input  kec_pkg::in_word_t          item,
	input  logic                       ent_vld,
	input  logic [DW-1:0]              ent,
	input  logic [kec_pkg::HOLD_W-1:0] hold_time,
	output kec_pkg::upd_t              res,
	output logic [DW-1:0]              new_ent
);
	import kec_pkg::*;

	localparam int TW = TIME_WIDTH;
	localparam int CW = (TW > HOLD_W) ? TW : HOLD_W;

	logic [POS_W-1:0]        pos, prev, e_pos;
	logic signed [SUM_W-1:0] sum, e_sum, sum_sat, gain_lvl;
	logic [TW-1:0]           lt, e_time, t, diff;
	logic signed [5:0]       step;
	logic signed [10:0]      acc;
	logic signed [11:0]      rel;
	logic [6:0]              rel_val;
	logic                    in_hold, in_rng;
	logic [POS_W-1:0]        n_pos;
	logic signed [SUM_W-1:0] n_sum;
	logic [TW-1:0]           n_time;

	assign e_pos  = ent[DW-1 -: POS_W];
	assign e_sum  = $signed(ent[TW +: SUM_W]);
	assign e_time = ent[TW-1:0];

	// an entry never written reads as its reset value
	assign pos  = item.raw_reading[POS_W-1:0];
	assign prev = ent_vld ? e_pos : '0;
	assign sum  = ent_vld ? e_sum : '0;
	assign lt   = ent_vld ? e_time : '0;
	assign t    = TW'(item.timestamp);
	assign diff = t - lt;
	assign in_hold = CW'(diff) < CW'(hold_time);
	assign in_rng = 32'(item.knob_index) < NUM_KNOBS;

	always_comb begin
		if (pos <= 4'd3 && prev >= 4'd12) begin
			step = 6'sd16 + $signed({2'b00, pos}) - $signed({2'b00, prev});
		end else if (pos >= 4'd12 && prev <= 4'd3) begin
			step = $signed({2'b00, pos}) - 6'sd16 - $signed({2'b00, prev});
		end else begin
			step = $signed({2'b00, pos}) - $signed({2'b00, prev});
		end
	end

	assign acc = 11'(sum) + 11'(step);

	always_comb begin
		if (acc > 11'(SUM_MAX)) begin
			sum_sat = SUM_MAX;
		end else if (acc < 11'(SUM_MIN)) begin
			sum_sat = SUM_MIN;
		end else begin
			sum_sat = acc[SUM_W-1:0];
		end
	end

	// relative emit uses the unsaturated sum
	assign rel = $signed({5'b0, CENTER}) + 12'(sum) + 12'(step);

	always_comb begin
		if (rel > $signed({5'b0, TOP})) begin
			rel_val = TOP;
		end else if (rel < 12'sd0) begin
			rel_val = '0;
		end else begin
			rel_val = rel[6:0];
		end
	end

	always_comb begin
		if (sum_sat > $signed({3'b0, TOP})) begin
			gain_lvl = $signed({3'b0, TOP});
		end else if (sum_sat < 10'sd0) begin
			gain_lvl = '0;
		end else begin
			gain_lvl = sum_sat;
		end
	end

	always_comb begin
		res.wr    = 1'b0;
		res.emit  = 1'b0;
		res.value = '0;
		n_pos     = pos;
		n_sum     = sum;
		n_time    = lt;
		case (item.mode)
			MODE_POT: begin
				res.emit  = 1'b1;
				res.value = $signed({1'b0, item.raw_reading[11:5]});
			end
			MODE_MOVE: begin
				res.wr    = 1'b1;
				res.emit  = 1'b1;
				n_time    = t;
				if (!ent_vld || pos == prev) begin
					res.value = '0;
				end else if (pos > prev) begin
					res.value = 8'sd1;
				end else begin
					res.value = -8'sd1;
				end
			end
			MODE_REL: begin
				res.wr = 1'b1;
				if (!ent_vld) begin
					n_time = t;
				end else if (in_hold) begin
					n_sum = sum_sat;
				end else begin
					res.emit  = 1'b1;
					res.value = $signed({1'b0, rel_val});
					n_sum     = '0;
					n_time    = t;
				end
			end
			MODE_GAIN: begin
				res.wr = 1'b1;
				if (!ent_vld) begin
					res.emit  = 1'b1;
					res.value = $signed({1'b0, CENTER});
					n_sum     = $signed({3'b0, CENTER});
					n_time    = t;
				end else if (in_hold) begin
					n_sum = sum_sat;
				end else begin
					res.emit  = 1'b1;
					res.value = 8'(gain_lvl);
					n_sum     = gain_lvl;
					n_time    = t;
				end
			end
			default: begin
				res.wr = 1'b0;
			end
		endcase
		if (!in_rng) begin
			res.wr   = 1'b0;
			res.emit = 1'b0;
		end
	end

	assign new_ent = {n_pos, n_sum, n_time};

endmodule

// ===== hdl/knob_encoder_to_cc_value.sv =====
// Knob event to control value converter, top level.
//
// Input channel in_valid/in_ready carries one event word: knob index, mode,
// raw reading and timestamp. Output channel out_valid/out_ready carries at
// most one result word per event: value and knob index. Events in pot and
// move mode always give a result, as does a knob's first gain event; other
// relative and gain events give one only once the hold time has passed, and
// unmapped modes or knobs give none. Configuration channel cfg_valid/cfg_ready
// writes hold_time; it is always ready, and the user writes it only while no
// event is in flight, as the block does not enforce this.
// One event per cycle is taken unless the output is blocked. An accepted event
// is held in the update stage, then its result goes to the output register.
// The rate rests on the per-knob read-modify-write: the state memory read is
// registered, the update is written back as the event leaves the update stage,
// and a following event on the same knob takes it from a bypass register.
// When out_ready is low and the output register is full, an event that
// emits waits in the update stage and input is held off; events without a
// result still pass. Reset clears per-knob valid bits (memory needs no
// clearing), empties the pipeline and sets hold_time to 5.
module knob_encoder_to_cc_value #(
	parameter int NUM_KNOBS  = kec_pkg::NUM_KNOBS_DEF,
	parameter int TIME_WIDTH = kec_pkg::TIME_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [kec_pkg::HOLD_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  kec_pkg::in_word_t          in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output kec_pkg::out_word_t         out_data
);
	import kec_pkg::*;

	localparam int AW = (NUM_KNOBS > 1) ? $clog2(NUM_KNOBS) : 1;
	localparam int DW = POS_W + SUM_W + TIME_WIDTH;

	logic [HOLD_W-1:0]    hold_q;
	logic [NUM_KNOBS-1:0] pvalid_q;
	logic                 ovalid_q;

	logic          valid_s1, evld_s1, fwd_s1;
	in_word_t      item_s1;
	logic [DW-1:0] fwd_ent_s1;

	logic          in_acc, in_rng, s1_fire, s1_wr, out_free, fwd_hit;
	logic [AW-1:0] raddr, waddr;
	logic [DW-1:0] ram_rdata, ent, new_ent;
	upd_t          res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= HOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			hold_q <= cfg_data;
		end
	end

	assign out_free = !ovalid_q || out_ready;
	assign s1_fire  = valid_s1 && (!res.emit || out_free);
	assign s1_wr    = s1_fire && res.wr;
	assign in_ready = !valid_s1 || s1_fire;
	assign in_acc   = in_valid && in_ready;
	assign in_rng   = 32'(in_data.knob_index) < NUM_KNOBS;
	assign raddr    = AW'(in_data.knob_index);
	assign waddr    = AW'(item_s1.knob_index);
	// same knob written back on the edge this word reads
	assign fwd_hit  = s1_wr && (item_s1.knob_index == in_data.knob_index);

	kec_state_ram #(
		.DEPTH (NUM_KNOBS),
		.AW    (AW),
		.DW    (DW)
	) u_ram (
		.clk   (clk),
		.we    (s1_wr),
		.waddr (waddr),
		.wdata (new_ent),
		.re    (in_acc),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1    <= in_data;
			fwd_s1     <= fwd_hit;
			fwd_ent_s1 <= new_ent;
			evld_s1    <= fwd_hit || (in_rng && pvalid_q[raddr]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvalid_q <= '0;
		end else if (s1_wr) begin
			pvalid_q[waddr] <= 1'b1;
		end
	end

	assign ent = fwd_s1 ? fwd_ent_s1 : ram_rdata;

	kec_update #(
		.NUM_KNOBS  (NUM_KNOBS),
		.TIME_WIDTH (TIME_WIDTH),
		.DW         (DW)
	) u_upd (
		.item      (item_s1),
		.ent_vld   (evld_s1),
		.ent       (ent),
		.hold_time (hold_q),
		.res       (res),
		.new_ent   (new_ent)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (s1_fire && res.emit) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && res.emit) begin
			out_data.out_value <= res.value;
			out_data.out_knob  <= item_s1.knob_index;
		end
	end

	assign out_valid = ovalid_q;

	a_fwd_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && fwd_hit) |=> (valid_s1 && fwd_s1 && evld_s1))
		else $error("bypass not taken for back-to-back word on same knob");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_fire) |=> (valid_s1 && $stable(item_s1)))
		else $error("update stage word lost while stalled");

	a_emit_out: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && res.emit) |=> ovalid_q)
		else $error("emitted word did not reach output register");

	a_no_write_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && res.emit && !out_free) |-> (!s1_wr && !in_ready))
		else $error("state written or input taken while result blocked");

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the knob event to control value converter.
`timescale 1ns / 1ps

module testbench;
	import kec_pkg::*;

	localparam logic [2:0] MODE_UNMAPPED = 3'd4;
	localparam logic [2:0] MODE_UNDEF    = 3'd7;
	localparam int         N_KNOBS       = 64;
	localparam int         N_DIR         = 23;
	localparam int         N_PHASES      = 9;
	localparam int         PHASE_ITEMS   = 200;
	localparam int         LONG_STALL    = 400;

	typedef struct packed {
		logic [5:0]        knob;
		logic [2:0]        mode;
		logic [11:0]       raw;
		logic [31:0]       ts;
		logic              pinned;
		logic              emits;
		logic signed [7:0] value;
	} row_t;

	// directed rows; value is typed in only where the row is pinned
	row_t dir_rows [N_DIR] = '{
		'{6'd0,  MODE_POT,      12'h000, 32'd0,        1'b1, 1'b1, 8'sd0},
		'{6'd63, MODE_POT,      12'hfff, 32'hffffffff, 1'b1, 1'b1, 8'sd127},
		'{6'd5,  MODE_UNMAPPED, 12'hfff, 32'h12345678, 1'b1, 1'b0, 8'sd0},
		'{6'd5,  MODE_UNDEF,    12'h000, 32'd0,        1'b1, 1'b0, 8'sd0},
		'{6'd1,  MODE_REL,      12'h00e, 32'd100,      1'b1, 1'b0, 8'sd0},
		'{6'd1,  MODE_REL,      12'h00f, 32'd101,      1'b0, 1'b0, 8'sd0},
		'{6'd1,  MODE_REL,      12'h001, 32'd102,      1'b0, 1'b0, 8'sd0},
		'{6'd1,  MODE_REL,      12'h003, 32'd200,      1'b0, 1'b0, 8'sd0},
		'{6'd1,  MODE_REL,      12'hff3, 32'd201,      1'b0, 1'b0, 8'sd0},
		'{6'd2,  MODE_GAIN,     12'h002, 32'd0,        1'b1, 1'b1, 8'sd63},
		'{6'd2,  MODE_GAIN,     12'h00e, 32'd10,       1'b0, 1'b0, 8'sd0},
		'{6'd2,  MODE_GAIN,     12'h00e, 32'd11,       1'b0, 1'b0, 8'sd0},
		'{6'd3,  MODE_MOVE,     12'h005, 32'd7,        1'b1, 1'b1, 8'sd0},
		'{6'd3,  MODE_MOVE,     12'h009, 32'd8,        1'b1, 1'b1, 8'sd1},
		'{6'd3,  MODE_MOVE,     12'h001, 32'd8,        1'b1, 1'b1, -8'sd1},
		'{6'd3,  MODE_MOVE,     12'h001, 32'd9,        1'b1, 1'b1, 8'sd0},
		'{6'd3,  MODE_MOVE,     12'hff0, 32'd9,        1'b1, 1'b1, -8'sd1},
		'{6'd4,  MODE_GAIN,     12'ha50, 32'hfffffff0, 1'b1, 1'b1, 8'sd63},
		'{6'd4,  MODE_GAIN,     12'h00b, 32'h00000010, 1'b0, 1'b0, 8'sd0},
		'{6'd0,  MODE_REL,      12'h000, 32'd0,        1'b1, 1'b0, 8'sd0},
		'{6'd0,  MODE_REL,      12'h000, 32'd4,        1'b0, 1'b0, 8'sd0},
		'{6'd0,  MODE_REL,      12'h000, 32'd9,        1'b0, 1'b0, 8'sd0},
		'{6'd63, MODE_POT,      12'h7e0, 32'd5,        1'b1, 1'b1, 8'sd63}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_word_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_word_t   out_data;

	// pinned expectation travelling alongside the offered word
	logic        pin_on = 1'b0;
	logic        pin_emit = 1'b0;
	out_word_t   pin_word = '0;

	int sender_idle_pct = 20;
	int recv_idle_pct = 54;
	int stall_req = 0;
	int stall_ack = 0;
	int stall_left = 0;
	int err_count = 0;

	// predictor state
	logic [15:0]       hold_time = HOLD_RESET;
	logic [3:0]        last_pos [N_KNOBS];
	bit                pos_seen [N_KNOBS];
	logic signed [9:0] step_acc [N_KNOBS];
	logic [31:0]       emit_time [N_KNOBS];
	out_word_t         cc_expected [$];

	// stimulus side copy of the hold time and the running clock of events
	logic [15:0] hold_now = HOLD_RESET;
	logic [31:0] ts_now;

	knob_encoder_to_cc_value dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report_error(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		err_count++;
	endtask

	function automatic int sat_acc(input int v);
		if (v > int'(SUM_MAX)) return int'(SUM_MAX);
		if (v < int'(SUM_MIN)) return int'(SUM_MIN);
		return v;
	endfunction

	function automatic int clamp_level(input int v);
		if (v > int'(TOP)) return int'(TOP);
		if (v < 0) return 0;
		return v;
	endfunction

	function automatic bit predict_cc(input in_word_t w, output out_word_t r);
		int          k;
		int          pos;
		int          prev;
		int          step;
		int          val;
		logic [31:0] dt;
		k = int'(w.knob_index);
		pos = int'(w.raw_reading[3:0]);
		r = '0;
		val = 0;
		if (w.mode > MODE_POT) return 1'b0;
		if (w.mode == MODE_POT) begin
			val = int'(w.raw_reading >> 5);
		end else if (!pos_seen[k]) begin
			last_pos[k] = w.raw_reading[3:0];
			pos_seen[k] = 1'b1;
			emit_time[k] = w.timestamp;
			if (w.mode == MODE_REL) return 1'b0;
			if (w.mode == MODE_GAIN) begin
				step_acc[k] = 10'(CENTER);
				val = int'(CENTER);
			end
		end else if (w.mode == MODE_MOVE) begin
			prev = int'(last_pos[k]);
			emit_time[k] = w.timestamp;
			val = (pos > prev) ? 1 : ((pos < prev) ? -1 : 0);
			last_pos[k] = w.raw_reading[3:0];
		end else begin
			prev = int'(last_pos[k]);
			// steps across the 16-position wrap
			if (pos <= 3 && prev >= 12) step = 16 - prev + pos;
			else if (pos >= 12 && prev <= 3) step = pos - 16 - prev;
			else step = pos - prev;
			last_pos[k] = w.raw_reading[3:0];
			dt = w.timestamp - emit_time[k];
			if (dt < {16'd0, hold_time}) begin
				step_acc[k] = 10'(sat_acc(int'(step_acc[k]) + step));
				return 1'b0;
			end
			emit_time[k] = w.timestamp;
			if (w.mode == MODE_REL) begin
				val = clamp_level(int'(CENTER) + int'(step_acc[k]) + step);
				step_acc[k] = '0;
			end else begin
				val = clamp_level(sat_acc(int'(step_acc[k]) + step));
				step_acc[k] = 10'(val);
			end
		end
		r.out_value = val[7:0];
		r.out_knob = w.knob_index;
		return 1'b1;
	endfunction

	// monitor: config, result check, then prediction of the accepted event
	always @(posedge clk) begin : monitor
		out_word_t got_exp;
		out_word_t pred;
		bit        emits;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) hold_time = cfg_data;
			if (out_valid && out_ready) begin
				if (cc_expected.size() == 0) begin
					report_error($sformatf("unexpected result value %0d knob %0d",
						out_data.out_value, out_data.out_knob));
				end else begin
					got_exp = cc_expected.pop_front();
					if (out_data.out_value !== got_exp.out_value)
						report_error($sformatf("value %0d, wanted %0d (knob %0d)",
							out_data.out_value, got_exp.out_value, got_exp.out_knob));
					if (out_data.out_knob !== got_exp.out_knob)
						report_error($sformatf("knob %0d, wanted %0d",
							out_data.out_knob, got_exp.out_knob));
				end
			end
			if (in_valid && in_ready) begin
				emits = predict_cc(in_data, pred);
				if (pin_on) begin
					if (pin_emit) cc_expected.push_back(pin_word);
				end else if (emits) begin
					cc_expected.push_back(pred);
				end
			end
		end
	end

	// receiver: random back-pressure, plus long hold-offs on request
	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (stall_req != stall_ack) begin
			out_ready <= 1'b0;
			stall_ack <= stall_req;
			stall_left <= LONG_STALL;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// called at a rising edge, returns at the edge that takes the word
	task automatic send_event(input in_word_t w, input logic pinned = 1'b0,
			input logic emits = 1'b0, input out_word_t pin_w = '0);
		bit rdy;
		if ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		in_valid <= 1'b1;
		in_data <= w;
		pin_on <= pinned;
		pin_emit <= emits;
		pin_word <= pin_w;
		do begin
			@(negedge clk);
			rdy = in_ready;
			@(posedge clk);
		end while (!rdy);
	endtask

	task automatic write_hold(input logic [15:0] v);
		bit rdy;
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do begin
			@(negedge clk);
			rdy = cfg_ready;
			@(posedge clk);
		end while (!rdy);
		cfg_valid <= 1'b0;
		hold_now = v;
	endtask

	// stop offering, wait for every expected word, then let the pipe empty
	task automatic drain();
		int n;
		n = 0;
		in_valid <= 1'b0;
		while (cc_expected.size() != 0 && n < 20000) begin
			@(posedge clk);
			n++;
		end
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [31:0] next_stamp();
		int          r;
		logic [31:0] dt;
		r = $urandom_range(99);
		if (r < 30) dt = (hold_now == 0) ? 32'd0 : 32'($urandom_range(hold_now - 1));
		else if (r < 55) dt = 32'(hold_now) + 32'($urandom_range(2)) - 32'd1;
		else if (r < 92) dt = 32'($urandom_range(2 * hold_now + 8));
		else dt = $urandom;
		ts_now = ts_now + dt;
		return ts_now;
	endfunction

	task automatic random_phase(input int n_items);
		in_word_t w;
		int       sent;
		int       pick;
		int       len;
		int       pos;
		int       dir;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			if (pick < 10) begin
				// noise: any field, unmapped modes included
				w = in_word_t'({$urandom, $urandom});
				w.mode = 3'($urandom_range(7));
				send_event(w);
				if (w.mode <= MODE_POT) sent++;
			end else if (pick < 25) begin
				w.knob_index = 6'($urandom_range(63));
				w.mode = MODE_POT;
				w.raw_reading = 12'($urandom_range(4095));
				w.timestamp = next_stamp();
				send_event(w);
				sent++;
			end else if (pick < 30 && hold_now >= 1000) begin
				// steady +-4 steps inside the hold window drive the sum into saturation
				w.knob_index = 6'($urandom_range(63));
				w.mode = $urandom_range(1) ? MODE_REL : MODE_GAIN;
				pos = $urandom_range(15);
				dir = $urandom_range(1) ? 4 : -4;
				len = $urandom_range(130, 160);
				for (int i = 0; i < len; i++) begin
					pos = (pos + dir) & 15;
					w.raw_reading = {8'($urandom), 4'(pos)};
					ts_now = ts_now + 32'($urandom_range(1));
					w.timestamp = ts_now;
					send_event(w);
				end
				pos = (pos + dir) & 15;
				w.raw_reading = 12'(pos);
				ts_now = ts_now + 32'(hold_now) + 32'd1;
				w.timestamp = ts_now;
				send_event(w);
				sent += len + 1;
			end else begin
				w.knob_index = 6'($urandom_range(63));
				pick = $urandom_range(99);
				w.mode = (pick < 40) ? MODE_REL : ((pick < 75) ? MODE_GAIN : MODE_MOVE);
				pos = $urandom_range(15);
				len = $urandom_range(3, 16);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(9) == 0) pos = $urandom_range(15);
					else pos = (pos + $urandom_range(8) - 4) & 15;
					if ($urandom_range(9) == 0)
						w.mode = 3'($urandom_range(2));
					if ($urandom_range(99) < 30) w.raw_reading = {8'($urandom), 4'(pos)};
					else w.raw_reading = 12'(pos);
					w.timestamp = next_stamp();
					send_event(w);
				end
				sent += len;
			end
		end
	endtask

	initial begin
		in_word_t    w;
		out_word_t   pw;
		logic [15:0] hold_plan [N_PHASES];
		for (int i = 0; i < N_KNOBS; i++) begin
			last_pos[i] = '0;
			pos_seen[i] = 1'b0;
			step_acc[i] = '0;
			emit_time[i] = '0;
		end
		ts_now = $urandom;
		hold_plan = '{16'd0, 16'hffff, 16'd3, 16'($urandom_range(6, 200)), 16'hffff,
			16'd1, 16'd5, 16'($urandom), 16'd0};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++) begin
			w.knob_index = dir_rows[i].knob;
			w.mode = dir_rows[i].mode;
			w.raw_reading = dir_rows[i].raw;
			w.timestamp = dir_rows[i].ts;
			pw.out_value = dir_rows[i].value;
			pw.out_knob = dir_rows[i].knob;
			send_event(w, dir_rows[i].pinned, dir_rows[i].emits, pw);
		end

		for (int ph = 0; ph < N_PHASES; ph++) begin
			if (ph == 3) begin
				sender_idle_pct <= 54;
				recv_idle_pct <= 20;
			end else if (ph == 6) begin
				sender_idle_pct <= 0;
				recv_idle_pct <= 0;
			end
			drain();
			write_hold(hold_plan[ph]);
			if (ph == 1) begin
				// receiver holds off while pot words keep coming: the block backs up
				stall_req <= stall_req + 1;
				for (int i = 0; i < 80; i++) begin
					w.knob_index = 6'($urandom_range(63));
					w.mode = MODE_POT;
					w.raw_reading = 12'($urandom_range(4095));
					w.timestamp = next_stamp();
					send_event(w);
				end
			end
			random_phase(PHASE_ITEMS);
		end

		drain();
		if (cc_expected.size() != 0)
			report_error($sformatf("%0d expected words never arrived", cc_expected.size()));
		if (err_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/kec_pkg.sv
hdl/kec_state_ram.sv
hdl/kec_update.sv
hdl/knob_encoder_to_cc_value.sv
bench/testbench.sv
